/* rtl/core/v3n_pkg.sv */
package v3n_pkg;

   localparam int DEF_COMPONENT_BITS = 16;
   localparam int DEF_FRACTION_BITS  = 8;

   localparam int UNIT_W    = 16;
   localparam int UNIT_FRAC = 15;

   localparam logic [UNIT_W-1:0] UNIT_POS_SAT = {1'b0, {(UNIT_W-1){1'b1}}};
   localparam logic [UNIT_W-1:0] UNIT_NEG_SAT = {1'b1, {(UNIT_W-1){1'b0}}};

endpackage

/* rtl/core/vector3_normalizer_core.sv */
// 3D vector normalizer: length and Q1.15 unit vector of a signed vector.
// Request channel: req_valid/req_ready with req_vec_x/y/z, two's complement.
// Response channel: rsp_valid/rsp_ready with rsp_unit_x/y/z (Q1.15, saturated),
// rsp_length (COMPONENT_BITS+FRACTION_BITS bits, FRACTION_BITS fraction bits,
// floored) and rsp_zero_vector (all components zero; units and length 0).
// Throughput: one transaction per cycle, sustained while the receiver takes responses.
// Pipeline: magnitude, square and sum registers, then the square root, which
// resolves one root bit per stage, then three restoring dividers that resolve
// one quotient bit per stage in parallel, then the output register.
// Each transaction's valid bit travels with its data through the stages.
// Reset clears every valid bit; data registers are not reset.
// When the receiver stalls, the whole pipeline holds in place and req_ready
// drops; nothing is lost or repeated, and transactions keep entering while
// the output register is empty or being drained.
module vector3_normalizer_core #(
   parameter int COMPONENT_BITS = v3n_pkg::DEF_COMPONENT_BITS,
   parameter int FRACTION_BITS  = v3n_pkg::DEF_FRACTION_BITS
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_valid,
   output logic                                           req_ready,
   input  logic signed [COMPONENT_BITS-1:0]               req_vec_x,
   input  logic signed [COMPONENT_BITS-1:0]               req_vec_y,
   input  logic signed [COMPONENT_BITS-1:0]               req_vec_z,
   output logic                                           rsp_valid,
   input  logic                                           rsp_ready,
   output logic signed [v3n_pkg::UNIT_W-1:0]              rsp_unit_x,
   output logic signed [v3n_pkg::UNIT_W-1:0]              rsp_unit_y,
   output logic signed [v3n_pkg::UNIT_W-1:0]              rsp_unit_z,
   output logic [COMPONENT_BITS+FRACTION_BITS-1:0]        rsp_length,
   output logic                                           rsp_zero_vector
);
   import v3n_pkg::*;

   localparam int CB = COMPONENT_BITS;
   localparam int LW = COMPONENT_BITS + FRACTION_BITS;
   localparam int SW = 2 * CB;
   localparam int RW = 2 * LW;
   localparam int D  = LW + UNIT_W;

   logic en;

   logic          v1_ff, v2_ff, v3_ff;
   logic [2:0]    neg1_ff, neg2_ff, neg3_ff;
   logic [CB-1:0] mx1_ff, my1_ff, mz1_ff;
   logic [CB-1:0] mx2_ff, my2_ff, mz2_ff;
   logic [SW-1:0] sx2_ff, sy2_ff, sz2_ff;
   logic [CB-1:0] mx3_ff, my3_ff, mz3_ff;
   logic [SW-1:0] sum3_ff;
   logic          zero3_ff;

   logic          vs_ff   [D];
   logic [2:0]    negs_ff [D];
   logic          zeros_ff[D];
   logic [CB-1:0] mxs_ff  [LW];
   logic [CB-1:0] mys_ff  [LW];
   logic [CB-1:0] mzs_ff  [LW];
   logic [LW-1:0] lens_ff [UNIT_W];

   logic [LW-1:0]     root;
   logic [UNIT_W-1:0] qx, qy, qz;

   logic                     rsp_valid_ff;
   logic [UNIT_W-1:0]        ux_ff, uy_ff, uz_ff;
   logic [LW-1:0]            len_ff;
   logic                     zero_ff;

   function automatic logic [CB-1:0] mag_of(input logic [CB-1:0] v);
      return v[CB-1] ? CB'(~v + 1'b1) : v;
   endfunction

   function automatic logic [UNIT_W-1:0] sat_of(input logic [UNIT_W-1:0] q, input logic neg,
                                                input logic zero);
      logic [UNIT_W-1:0] r;
      if (zero) begin
         r = '0;
      end else if (neg) begin
         r = q[UNIT_W-1] ? UNIT_NEG_SAT : UNIT_W'(~q + 1'b1);
      end else begin
         r = q[UNIT_W-1] ? UNIT_POS_SAT : q;
      end
      return r;
   endfunction

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff <= {req_vec_z[CB-1], req_vec_y[CB-1], req_vec_x[CB-1]};
         mx1_ff  <= mag_of(req_vec_x);
         my1_ff  <= mag_of(req_vec_y);
         mz1_ff  <= mag_of(req_vec_z);
         neg2_ff <= neg1_ff;
         mx2_ff  <= mx1_ff;
         my2_ff  <= my1_ff;
         mz2_ff  <= mz1_ff;
         sx2_ff  <= SW'(mx1_ff) * SW'(mx1_ff);
         sy2_ff  <= SW'(my1_ff) * SW'(my1_ff);
         sz2_ff  <= SW'(mz1_ff) * SW'(mz1_ff);
         neg3_ff  <= neg2_ff;
         mx3_ff   <= mx2_ff;
         my3_ff   <= my2_ff;
         mz3_ff   <= mz2_ff;
         sum3_ff  <= SW'(sx2_ff + sy2_ff + sz2_ff);
         zero3_ff <= (mx2_ff == '0) && (my2_ff == '0) && (mz2_ff == '0);
      end
   end

   v3n_isqrt #(
      .COMPONENT_BITS(COMPONENT_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_isqrt (
      .clock(clock),
      .en   (en),
      .rad  (RW'(sum3_ff) << (2 * FRACTION_BITS)),
      .root (root)
   );

   for (genvar k = 0; k < D; k++) begin : g_side
      logic       v_p;
      logic [2:0] neg_p;
      logic       zero_p;

      if (k == 0) begin : g_first
         assign v_p    = v3_ff;
         assign neg_p  = neg3_ff;
         assign zero_p = zero3_ff;
      end else begin : g_next
         assign v_p    = vs_ff[k-1];
         assign neg_p  = negs_ff[k-1];
         assign zero_p = zeros_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vs_ff[k] <= 1'b0;
         end else if (en) begin
            vs_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            negs_ff[k]  <= neg_p;
            zeros_ff[k] <= zero_p;
         end
      end
   end

   for (genvar k = 0; k < LW; k++) begin : g_mag
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (en) begin
               mxs_ff[k] <= mx3_ff;
               mys_ff[k] <= my3_ff;
               mzs_ff[k] <= mz3_ff;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (en) begin
               mxs_ff[k] <= mxs_ff[k-1];
               mys_ff[k] <= mys_ff[k-1];
               mzs_ff[k] <= mzs_ff[k-1];
            end
         end
      end
   end

   for (genvar k = 0; k < UNIT_W; k++) begin : g_len
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (en) begin
               lens_ff[k] <= root;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (en) begin
               lens_ff[k] <= lens_ff[k-1];
            end
         end
      end
   end

   v3n_divider #(
      .COMPONENT_BITS(COMPONENT_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div_x (
      .clock(clock), .en(en), .mag(mxs_ff[LW-1]), .len(root), .quot(qx)
   );

   v3n_divider #(
      .COMPONENT_BITS(COMPONENT_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div_y (
      .clock(clock), .en(en), .mag(mys_ff[LW-1]), .len(root), .quot(qy)
   );

   v3n_divider #(
      .COMPONENT_BITS(COMPONENT_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div_z (
      .clock(clock), .en(en), .mag(mzs_ff[LW-1]), .len(root), .quot(qz)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vs_ff[D-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ux_ff   <= sat_of(qx, negs_ff[D-1][0], zeros_ff[D-1]);
         uy_ff   <= sat_of(qy, negs_ff[D-1][1], zeros_ff[D-1]);
         uz_ff   <= sat_of(qz, negs_ff[D-1][2], zeros_ff[D-1]);
         len_ff  <= zeros_ff[D-1] ? '0 : lens_ff[UNIT_W-1];
         zero_ff <= zeros_ff[D-1];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_unit_x      = ux_ff;
   assign rsp_unit_y      = uy_ff;
   assign rsp_unit_z      = uz_ff;
   assign rsp_length      = len_ff;
   assign rsp_zero_vector = zero_ff;

`ifndef NO_ASSERTIONS
   a_zero_outputs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_vector |->
         rsp_length == '0 && rsp_unit_x == '0 && rsp_unit_y == '0 && rsp_unit_z == '0)
      else $error("zero vector with nonzero outputs");

   a_nonzero_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_vector |-> rsp_length != '0)
      else $error("nonzero vector with zero length");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vs_ff[0]) && $stable(v3_ff))
      else $error("pipeline moved during stall");
`endif

endmodule

/* rtl/core/v3n_isqrt.sv */
module v3n_isqrt #(
   parameter int COMPONENT_BITS = v3n_pkg::DEF_COMPONENT_BITS,
   parameter int FRACTION_BITS  = v3n_pkg::DEF_FRACTION_BITS
) (
   input  logic                                         clock,
   input  logic                                         en,
   input  logic [2*(COMPONENT_BITS+FRACTION_BITS)-1:0]  rad,
   output logic [COMPONENT_BITS+FRACTION_BITS-1:0]      root
);
   import v3n_pkg::*;

   localparam int QW = COMPONENT_BITS + FRACTION_BITS;
   localparam int RW = 2 * QW;
   localparam int MW = QW + 2;

   logic [MW-1:0] rem_ff  [QW];
   logic [QW-1:0] root_ff [QW];
   logic [RW-1:0] rad_ff  [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [MW-1:0] rem_p;
      logic [QW-1:0] root_p;
      logic [RW-1:0] rad_p;
      logic [MW+1:0] cur;
      logic [MW+1:0] trial;
      logic          ge;
      logic [MW-1:0] rem_in;
      logic [QW-1:0] root_in;
      logic [RW-1:0] rad_in;

      if (k == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = rad;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign rad_p  = rad_ff[k-1];
      end

      always_comb begin
         cur     = {rem_p, rad_p[RW-1:RW-2]};
         trial   = {2'b00, root_p, 2'b01};
         ge      = (cur >= trial);
         rem_in  = ge ? MW'(cur - trial) : MW'(cur);
         root_in = {root_p[QW-2:0], ge};
         rad_in  = rad_p << 2;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_in;
         end
      end
   end

   assign root = root_ff[QW-1];

endmodule

/* rtl/core/v3n_divider.sv */
module v3n_divider #(
   parameter int COMPONENT_BITS = v3n_pkg::DEF_COMPONENT_BITS,
   parameter int FRACTION_BITS  = v3n_pkg::DEF_FRACTION_BITS
) (
   input  logic                                     clock,
   input  logic                                     en,
   input  logic [COMPONENT_BITS-1:0]                mag,
   input  logic [COMPONENT_BITS+FRACTION_BITS-1:0]  len,
   output logic [v3n_pkg::UNIT_W-1:0]               quot
);
   import v3n_pkg::*;

   localparam int LW = COMPONENT_BITS + FRACTION_BITS;
   localparam int NW = LW + UNIT_FRAC;

   logic [NW-1:0] num;

   logic [LW-1:0]     rem_ff  [UNIT_W];
   logic [LW-1:0]     len_ff  [UNIT_W];
   logic [UNIT_W-1:0] low_ff  [UNIT_W];
   logic [UNIT_W-1:0] quot_ff [UNIT_W];

   assign num = NW'(mag) << (FRACTION_BITS + UNIT_FRAC);

   for (genvar k = 0; k < UNIT_W; k++) begin : g_stage
      logic [LW-1:0]     rem_p;
      logic [LW-1:0]     len_p;
      logic [UNIT_W-1:0] low_p;
      logic [UNIT_W-1:0] quot_p;
      logic [LW:0]       cur;
      logic              ge;
      logic [LW-1:0]     rem_in;

      if (k == 0) begin : g_first
         assign rem_p  = LW'(num[NW-1:UNIT_W]);
         assign len_p  = len;
         assign low_p  = num[UNIT_W-1:0];
         assign quot_p = '0;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign len_p  = len_ff[k-1];
         assign low_p  = low_ff[k-1];
         assign quot_p = quot_ff[k-1];
      end

      always_comb begin
         cur    = {rem_p, low_p[UNIT_W-1]};
         ge     = (cur >= {1'b0, len_p});
         rem_in = ge ? LW'(cur - {1'b0, len_p}) : LW'(cur);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            len_ff[k]  <= len_p;
            low_ff[k]  <= low_p << 1;
            quot_ff[k] <= {quot_p[UNIT_W-2:0], ge};
         end
      end
   end

   assign quot = quot_ff[UNIT_W-1];

endmodule

/* tb/sv/tb_vector3_normalizer_core.sv */
module tb_vector3_normalizer_core;
   import v3n_pkg::*;

   localparam int CB = DEF_COMPONENT_BITS;
   localparam int FB = DEF_FRACTION_BITS;
   localparam int LW = CB + FB;
   localparam int LATENCY = 3 + LW + 16 + 1;
   localparam int N_RANDOM = 900;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [UNIT_W-1:0] ux;
      logic signed [UNIT_W-1:0] uy;
      logic signed [UNIT_W-1:0] uz;
      logic [LW-1:0]            len;
      logic                     zero;
   } norm_type;

   typedef struct {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic signed [CB-1:0] z;
      bit                   typed;
      norm_type             res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [CB-1:0] req_vec_x = '0;
   logic signed [CB-1:0] req_vec_y = '0;
   logic signed [CB-1:0] req_vec_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [UNIT_W-1:0] rsp_unit_x, rsp_unit_y, rsp_unit_z;
   logic [LW-1:0] rsp_length;
   logic rsp_zero_vector;

   norm_type pending_norms[$];
   int    errors = 0;
   longint cycles = 0;
   int    send_idle_pct = 0;
   int    recv_stall_pct = 0;

   vector3_normalizer_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_vec_x(req_vec_x), .req_vec_y(req_vec_y), .req_vec_z(req_vec_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_unit_x(rsp_unit_x), .rsp_unit_y(rsp_unit_y), .rsp_unit_z(rsp_unit_z),
      .rsp_length(rsp_length), .rsp_zero_vector(rsp_zero_vector)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] floor_root(logic [127:0] rad);
      logic [63:0] root;
      logic [127:0] trial;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         trial = {64'd0, root | (64'd1 << b)};
         if (trial * trial <= rad) root = root | (64'd1 << b);
      end
      return root;
   endfunction

   function automatic logic [UNIT_W-1:0] unit_comp(logic signed [CB-1:0] c,
                                                  logic [63:0] len);
      logic [63:0] mag, q;
      bit neg;
      neg = c < 0;
      mag = neg ? 64'(-64'(c)) : 64'(c);
      q = (mag << (FB + UNIT_FRAC)) / len;
      if (neg) begin
         if (q > 64'd32768) q = 64'd32768;
         return UNIT_W'(-q);
      end
      if (q > 64'd32767) q = 64'd32767;
      return UNIT_W'(q);
   endfunction

   function automatic norm_type normalize(logic signed [CB-1:0] x,
                                          logic signed [CB-1:0] y,
                                          logic signed [CB-1:0] z);
      norm_type r;
      logic [63:0] sum, len;
      sum = 64'(longint'(x) * longint'(x) + longint'(y) * longint'(y)
                + longint'(z) * longint'(z));
      if (sum == 0) begin
         r = '0;
         r.zero = 1'b1;
         return r;
      end
      len = floor_root({64'd0, sum} << (2 * FB));
      r.ux = unit_comp(x, len);
      r.uy = unit_comp(y, len);
      r.uz = unit_comp(z, len);
      r.len = LW'(len);
      r.zero = 1'b0;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   task automatic send_vector(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
                              logic signed [CB-1:0] z, bit typed, norm_type res);
      norm_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      want = normalize(x, y, z);
      if (typed && want !== res) report_mismatch("typed row", res, want);
      req_valid <= 1'b1;
      req_vec_x <= x;
      req_vec_y <= y;
      req_vec_z <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_norms.push_back(typed ? res : want);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_norms.size() == 0) begin
               report_mismatch("unexpected transaction", 1, 0);
            end else begin
               norm_type w;
               w = pending_norms.pop_front();
               if (rsp_unit_x !== w.ux) report_mismatch("unit_x", rsp_unit_x, w.ux);
               if (rsp_unit_y !== w.uy) report_mismatch("unit_y", rsp_unit_y, w.uy);
               if (rsp_unit_z !== w.uz) report_mismatch("unit_z", rsp_unit_z, w.uz);
               if (rsp_length !== w.len) report_mismatch("length", rsp_length, w.len);
               if (rsp_zero_vector !== w.zero)
                  report_mismatch("zero_vector", rsp_zero_vector, w.zero);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("** vector3_normalizer_core: FAILED **");
         $finish;
      end
   end

   function automatic logic signed [CB-1:0] rand_comp();
      case ($urandom_range(5))
         0: return CB'(int'($urandom_range(15)) - 8);
         1: return 16'sh7fff - CB'($urandom_range(3));
         2: return 16'sh8000 + CB'($urandom_range(3));
         default: return CB'($urandom);
      endcase
   endfunction

   stim_row_type stim_table[$];

   function automatic stim_row_type row(int x, int y, int z, bit typed = 0,
                                        int ux = 0, int uy = 0, int uz = 0,
                                        int len = 0, bit zero = 0);
      stim_row_type r;
      r.x = CB'(x); r.y = CB'(y); r.z = CB'(z);
      r.typed = typed;
      r.res = {UNIT_W'(ux), UNIT_W'(uy), UNIT_W'(uz), LW'(len), zero};
      return r;
   endfunction

   initial begin
      int phase_pct[4][2];
      int drain;
      phase_pct = '{'{0, 0}, '{87, 0}, '{0, 87}, '{24, 24}};
      stim_table.push_back(row(0, 0, 0, 1, 0, 0, 0, 0, 1));
      stim_table.push_back(row(1, 0, 0, 1, 32767, 0, 0, 256, 0));
      stim_table.push_back(row(0, -1, 0, 1, 0, -32768, 0, 256, 0));
      stim_table.push_back(row(0, 0, 32767, 1, 0, 0, 32767, 32767 * 256, 0));
      stim_table.push_back(row(-32768, 0, 0, 1, -32768, 0, 0, 32768 * 256, 0));
      stim_table.push_back(row(-32768, -32768, -32768, 1, -18918, -18918, -18918,
                               14529495, 0));
      stim_table.push_back(row(32767, 32767, 32767));
      stim_table.push_back(row(32767, -32768, 1));
      stim_table.push_back(row(3, 4, 0));
      stim_table.push_back(row(-3, 4, -12));
      stim_table.push_back(row(1, 1, 1));
      stim_table.push_back(row(-1, -1, -1));
      stim_table.push_back(row(21845, -10923, 5461));
      stim_table.push_back(row(-21846, 10922, -5462));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (stim_table[i])
         send_vector(stim_table[i].x, stim_table[i].y, stim_table[i].z,
                     stim_table[i].typed, stim_table[i].res);
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = phase_pct[p][0];
         recv_stall_pct = phase_pct[p][1];
         for (int n = 0; n < N_RANDOM / 4; n++) begin
            if (p == 1 && n == 50) begin
               req_valid <= 1'b0;
               while (pending_norms.size() != 0) @(posedge clock);
            end
            send_vector(rand_comp(), rand_comp(), rand_comp(), 0, '0);
         end
      end
      req_valid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (pending_norms.size() != 0) @(posedge clock);
      drain = 0;
      while (drain < LATENCY * 2) begin
         @(posedge clock);
         drain++;
      end
      if (errors == 0 && pending_norms.size() == 0) begin
         $display("** vector3_normalizer_core: PASSED **");
      end else begin
         $display("** vector3_normalizer_core: FAILED **");
      end
      $finish;
   end

endmodule
